/* rtl/core/mccpb_pkg.sv */
// Shared types and constants for the MIDI control change to pitch bend rewriter.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package mccpb_pkg;

    // Input request: one MIDI message
    typedef struct packed {
        logic       explicit_status;
        logic [7:0] status_in;
        logic [1:0] data_count;
        logic [7:0] first_data;
        logic [7:0] second_data;
    } t_msg_in;

    // Result: the rewritten or untouched message
    typedef struct packed {
        logic [7:0] status_out;
        logic [7:0] first_out;
        logic [7:0] second_out;
        logic       converted;
    } t_msg_out;

    // Configuration register snapshot
    typedef struct packed {
        logic       enable;
        logic [6:0] controller_number;
        logic [5:0] dead_zone;
        logic [6:0] range_percent;
    } t_cfg;

    // Which part of the bend curve a value falls on
    typedef enum logic [1:0] {
        MODE_CENTER,
        MODE_UPPER,
        MODE_LOWER
    } t_bend_mode;

    // Per-request side data carried down the pipeline
    typedef struct packed {
        logic [7:0] status_in;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic       converted;
        t_bend_mode mode;
        logic       low_zero;
    } t_ctx;

    // Divider working set: remainder, shifted divisor, quotient so far
    localparam int unsigned DIV_W   = 27;
    localparam int unsigned QUO_W   = 14;
    localparam int unsigned DIV_STEPS = QUO_W;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
    } t_div;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE     = 2'd0;
    localparam logic [1:0] CFG_CONTROLLER = 2'd1;
    localparam logic [1:0] CFG_DEAD_ZONE  = 2'd2;
    localparam logic [1:0] CFG_RANGE      = 2'd3;

    // MIDI message type codes (status high nibble)
    localparam logic [3:0] TYPE_CC = 4'hB;
    localparam logic [3:0] TYPE_PB = 4'hE;

    localparam logic [1:0]  CC_DATA_COUNT = 2'd2;
    localparam logic [7:0]  VALUE_CENTER  = 8'd64;
    localparam logic [6:0]  PCT_SCALE     = 7'd100;
    localparam logic [13:0] BEND_CENTER   = 14'd8192;
    localparam logic [13:0] BEND_MAX      = 14'd16383;

    // Reset values of the configuration registers
    localparam t_cfg CFG_RESET = '{enable: 1'b1, controller_number: 7'd1,
                                   dead_zone: 6'd2, range_percent: 7'd100};

endpackage

/* rtl/core/midi_cc_to_pitch_bend.sv */
// Path: 3 front stages, 14 divider stages, 1 output register from the accepting
// edge to result valid; a request held in the skid enters when stages advance.
// One request per cycle unless the output stalls; the restoring divider sets depth.
// A stalled output freezes all stages; the input skid absorbs one request.
// Reset (synchronous, active low) empties every stage and loads register defaults.
`timescale 1ns / 1ps

module midi_cc_to_pitch_bend
    import mccpb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    // request channel
    input  logic     i_in_valid,
    input  t_msg_in  i_in_data,
    output logic     o_in_stall,
    // result channel
    output logic     o_out_valid,
    output t_msg_out o_out_data,
    input  logic     i_out_stall,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    t_cfg r_cfg;
    logic w_adv;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE:     r_cfg.enable            <= i_cfg_data[0];
                CFG_CONTROLLER: r_cfg.controller_number <= i_cfg_data;
                CFG_DEAD_ZONE:  r_cfg.dead_zone         <= i_cfg_data[5:0];
                CFG_RANGE:      r_cfg.range_percent     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance every stage unless the held result is not taken
    logic     r_out_valid;
    t_msg_out r_out_data;

    assign w_adv = !(r_out_valid && i_out_stall);

    // Input skid
    logic    w_feed_valid;
    t_msg_in w_feed_data;

    mccpb_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .i_adv   (w_adv),
        .o_valid (w_feed_valid),
        .o_data  (w_feed_data)
    );

    // Decode and operand stages
    logic w_stg_valid [0:DIV_STEPS];
    t_ctx w_stg_ctx   [0:DIV_STEPS];
    t_div w_stg_div   [0:DIV_STEPS];

    mccpb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cfg   (r_cfg),
        .i_valid (w_feed_valid),
        .i_msg   (w_feed_data),
        .o_valid (w_stg_valid[0]),
        .o_ctx   (w_stg_ctx[0]),
        .o_div   (w_stg_div[0])
    );

    // Divider pipeline, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        mccpb_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_stg_valid[k]),
            .i_ctx   (w_stg_ctx[k]),
            .i_div   (w_stg_div[k]),
            .o_valid (w_stg_valid[k+1]),
            .o_ctx   (w_stg_ctx[k+1]),
            .o_div   (w_stg_div[k+1])
        );
    end

    // Assemble the bend and the outgoing message
    t_ctx        w_ctx;
    logic [13:0] w_quo;
    logic [14:0] w_up_sum;
    logic [13:0] w_bend;
    t_msg_out    n_out_data;

    always_comb begin
        w_ctx    = w_stg_ctx[DIV_STEPS];
        w_quo    = w_stg_div[DIV_STEPS].quo;
        w_up_sum = {1'b0, BEND_CENTER} + {1'b0, w_quo};
        case (w_ctx.mode)
            MODE_UPPER: w_bend = (w_up_sum > {1'b0, BEND_MAX}) ? BEND_MAX : w_up_sum[13:0];
            MODE_LOWER: w_bend = w_ctx.low_zero ? 14'd0 : w_quo;
            default:    w_bend = BEND_CENTER;
        endcase

        if (w_ctx.converted) begin
            n_out_data.status_out = {TYPE_PB, w_ctx.status_in[3:0]};
            n_out_data.first_out  = {1'b0, w_bend[6:0]};
            n_out_data.second_out = {1'b0, w_bend[13:7]};
            n_out_data.converted  = 1'b1;
        end else begin
            n_out_data.status_out = w_ctx.status_in;
            n_out_data.first_out  = w_ctx.first_data;
            n_out_data.second_out = w_ctx.second_data;
            n_out_data.converted  = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_stg_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/core/mccpb_skid.sv */
// Input skid buffer: holds one request when the pipeline is frozen.
// Depends on mccpb_pkg for the message type.
`timescale 1ns / 1ps

module mccpb_skid
    import mccpb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_msg_in i_data,
    output logic    o_stall,
    input  logic    i_adv,
    output logic    o_valid,
    output t_msg_in o_data
);

    logic    r_full;
    logic    n_full;
    t_msg_in r_data;
    logic    w_acc;

    assign w_acc   = i_valid && !r_full;
    assign o_stall = r_full;

    // Feed the pipeline from the held request first
    assign o_valid = r_full || i_valid;
    assign o_data  = r_full ? r_data : i_data;

    // Fill when a request arrives while the pipeline holds, drain on advance
    always_comb begin
        n_full = r_full;
        if (i_adv) begin
            n_full = 1'b0;
        end else if (w_acc) begin
            n_full = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !i_adv) begin
            r_data <= i_data;
        end
    end

endmodule

/* rtl/core/mccpb_front.sv */
// Front three stages: decode and classify, ratio products, divider operands.
// Depends on mccpb_pkg for message, context and divider types.
`timescale 1ns / 1ps

module mccpb_front
    import mccpb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_msg_in i_msg,
    output logic    o_valid,
    output t_ctx    o_ctx,
    output t_div    o_div
);

    // ---------------- stage 1: match and classify ----------------
    logic       w_match;
    logic [7:0] w_val;
    logic [7:0] w_hi_thr;
    logic [7:0] w_n_up;
    logic [5:0] w_den_up;
    logic [6:0] w_den_lo;
    logic       w_up;
    logic       w_lo;
    t_ctx       n1_ctx;
    logic [6:0] n1_n;
    logic [6:0] n1_den;

    logic       r1_valid;
    t_ctx       r1_ctx;
    logic [6:0] r1_n;
    logic [6:0] r1_den;

    always_comb begin
        w_val    = i_msg.second_data;
        w_match  = i_cfg.enable && i_msg.explicit_status
                && (i_msg.status_in[7:4] == TYPE_CC)
                && (i_msg.data_count == CC_DATA_COUNT)
                && (i_msg.first_data == {1'b0, i_cfg.controller_number});
        w_hi_thr = VALUE_CENTER + {2'b00, i_cfg.dead_zone};
        w_up     = w_val > w_hi_thr;
        w_lo     = ({1'b0, w_val} + {3'b000, i_cfg.dead_zone}) < {1'b0, VALUE_CENTER};
        w_n_up   = w_val - w_hi_thr;
        w_den_up = 6'd63 - i_cfg.dead_zone;
        w_den_lo = VALUE_CENTER[6:0] - {1'b0, i_cfg.dead_zone};

        n1_ctx.status_in   = i_msg.status_in;
        n1_ctx.first_data  = i_msg.first_data;
        n1_ctx.second_data = i_msg.second_data;
        n1_ctx.converted   = w_match;
        n1_ctx.low_zero    = 1'b0;
        n1_n               = 7'd0;
        n1_den             = 7'd1;

        if (w_up) begin
            n1_ctx.mode = MODE_UPPER;
            // Clamp the ramp ratio at one (also covers a zero ramp length)
            if (w_den_up == 6'd0 || w_n_up > {2'b00, w_den_up}) begin
                n1_n   = 7'd1;
                n1_den = 7'd1;
            end else begin
                n1_n   = w_n_up[6:0];
                n1_den = {1'b0, w_den_up};
            end
        end else if (w_lo) begin
            // Value is below 64 here, so the distance never exceeds the ramp
            n1_ctx.mode = MODE_LOWER;
            n1_n        = w_den_lo - w_val[6:0];
            n1_den      = w_den_lo;
        end else begin
            n1_ctx.mode = MODE_CENTER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_ctx <= n1_ctx;
            r1_n   <= n1_n;
            r1_den <= n1_den;
        end
    end

    // ---------------- stage 2: distance times range, ramp times 100 ----------------
    logic        r2_valid;
    t_ctx        r2_ctx;
    logic [12:0] r2_nr;
    logic [12:0] r2_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= r1_valid;
        end
    end

    // Both products stay below 8192 (distance at most 64, range at most 127)
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_ctx <= r1_ctx;
            r2_nr  <= {6'd0, r1_n} * {6'd0, i_cfg.range_percent};
            r2_q   <= {6'd0, r1_den} * {6'd0, PCT_SCALE};
        end
    end

    // ---------------- stage 3: dividend and divisor ----------------
    logic [DIV_W-1:0] w_nr;
    logic [DIV_W-1:0] w_q;
    logic [DIV_W-1:0] w_up_num;
    logic [DIV_W-1:0] w_p2;
    logic [DIV_W-1:0] w_lo_top;
    logic             w_low_zero;
    t_ctx             n3_ctx;
    t_div             n3_div;

    logic r3_valid;
    t_ctx r3_ctx;
    t_div r3_div;

    always_comb begin
        w_nr       = {14'd0, r2_nr};
        w_q        = {14'd0, r2_q};
        // Upper: 2*n*rp*8191 + q, the added q gives round half up
        w_up_num   = (w_nr << 14) - (w_nr << 1) + w_q;
        // Lower: 16383*q - 2*n*rp*8192, negative or zero means clamp to 0
        w_p2       = w_nr << 14;
        w_lo_top   = (w_q << 14) - w_q;
        w_low_zero = w_p2 >= w_lo_top;

        n3_ctx          = r2_ctx;
        n3_ctx.low_zero = w_low_zero;
        n3_div.quo      = '0;
        // Divisor 2*q aligned to the top quotient bit
        n3_div.dvs      = {r2_q, 1'b0, 13'd0};
        case (r2_ctx.mode)
            MODE_UPPER: n3_div.rem = w_up_num;
            MODE_LOWER: n3_div.rem = w_low_zero ? '0 : (w_lo_top - w_p2);
            default:    n3_div.rem = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_ctx <= n3_ctx;
            r3_div <= n3_div;
        end
    end

    assign o_valid = r3_valid;
    assign o_ctx   = r3_ctx;
    assign o_div   = r3_div;

endmodule

/* rtl/core/mccpb_div_step.sv */
// One registered restoring-division step: yields one quotient bit per stage.
// Depends on mccpb_pkg for context and divider types.
`timescale 1ns / 1ps

module mccpb_div_step
    import mccpb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  logic i_valid,
    input  t_ctx i_ctx,
    input  t_div i_div,
    output logic o_valid,
    output t_ctx o_ctx,
    output t_div o_div
);

    logic r_valid;
    t_ctx r_ctx;
    t_div r_div;
    t_div n_div;
    logic w_ge;

    // Subtract the aligned divisor when it fits, then shift it down one place
    always_comb begin
        w_ge      = i_div.rem >= i_div.dvs;
        n_div.rem = w_ge ? (i_div.rem - i_div.dvs) : i_div.rem;
        n_div.dvs = i_div.dvs >> 1;
        n_div.quo = {i_div.quo[QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctx <= i_ctx;
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_div   = r_div;

endmodule

/* rtl/core/mccpb_checker.sv */
// Port-level checks for the pitch bend rewriter, bound to its top level.
// Depends on mccpb_pkg and on the ports of midi_cc_to_pitch_bend.
`timescale 1ns / 1ps

module mccpb_checker
    import mccpb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input t_msg_out   o_out_data,
    input logic       i_out_stall
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Rewritten messages are pitch bend with 7-bit data bytes
    a_conv_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.converted |->
            o_out_data.status_out[7:4] == TYPE_PB
            && !o_out_data.first_out[7] && !o_out_data.second_out[7])
        else $error("converted result is not a valid pitch bend");

    // Skid fills only when the output was stalled with a result held
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !$past(o_in_stall) |->
            $past(o_out_valid) && $past(i_out_stall) && $past(i_in_valid))
        else $error("input stalled without an output stall");

    // Skid drains as soon as the output is free
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !(o_out_valid && i_out_stall) |=> !o_in_stall)
        else $error("input stall held after output freed");

    // Reset empties both sides
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

endmodule

bind midi_cc_to_pitch_bend mccpb_checker u_mccpb_checker (.*);
